// ===== rtl/core/min_heap_priority_queue_unit_macros.svh =====
// Assertion macros shared by the heap queue RTL.
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define MHPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mhpq_pkg.sv =====
// Package with codes, field widths and shared types of the heap queue.
`default_nettype none

package mhpq_pkg;

  // Field widths on the stream ports
  localparam int OP_W            = 2;
  localparam int STATUS_W        = 2;
  localparam int KEY_FIELD_W     = 32;
  localparam int PAYLOAD_FIELD_W = 32;
  localparam int COUNT_FIELD_W   = 7;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;
  localparam op_t OP_NOP    = 2'd3;

  // Result status codes
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Result hand-over from the sequencer to the output register
  typedef struct packed {
    logic    done;
    status_t status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/min_heap_priority_queue_unit.sv =====
// Top level of the binary min-heap priority queue with its result register.
//
//   channel   dir  tdata (low bit first)                  tuser
//   s_axis    in   key[31:0], payload[31:0]               op[1:0]
//   m_axis    out  front_key, front_payload, entry_count  status[1:0]
//
// Insert climbs a level at a time, pulling each larger parent down, until the
// entry meets a parent that is not larger or reaches the root. Remove refills
// the root with the last entry and sifts it down past the smaller child until
// no child is smaller. Clear, no-op, refused operations and removing the last
// entry need no store access.
// The single read port of the heap store sets the cost of each level.
// rst is synchronous and empties the heap; store contents are not cleared.
// A waiting result sits in the output register; the next operation may
// start meanwhile, and finishes only once that register is free.
`default_nettype none
`include "min_heap_priority_queue_unit_macros.svh"

module min_heap_priority_queue_unit #(
  parameter int CAPACITY     = 64,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // key[31:0], payload[63:32]
  input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // front_key[31:0], front_payload[63:32],
                                          // entry_count[70:64], zero[71]
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = KEY_BITS + PAYLOAD_BITS;
  localparam int KFW = mhpq_pkg::KEY_FIELD_W;
  localparam int PFW = mhpq_pkg::PAYLOAD_FIELD_W;
  localparam int NFW = mhpq_pkg::COUNT_FIELD_W;

  logic [KFW+KEY_BITS-1:0]     in_key_wide;
  logic [PFW+PAYLOAD_BITS-1:0] in_pay_wide;
  logic [KEY_BITS+KFW-1:0]     root_key_wide;
  logic [PAYLOAD_BITS+PFW-1:0] root_pay_wide;
  logic [CW+NFW-1:0]           cnt_wide;

  mhpq_pkg::res_t    res;
  logic [DW-1:0]     root;
  logic [CW-1:0]     count;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DW-1:0]     wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [DW-1:0]     rdata;
  logic              out_free;

  logic              out_valid;
  logic [KFW-1:0]    out_key;
  logic [PFW-1:0]    out_payload;
  logic [NFW-1:0]    out_count;
  mhpq_pkg::status_t out_status;

  // Fit the input fields to the stored widths
  assign in_key_wide = {{KEY_BITS{1'b0}}, s_axis_tdata[KFW-1:0]};
  assign in_pay_wide = {{PAYLOAD_BITS{1'b0}}, s_axis_tdata[KFW+PFW-1:KFW]};

  mhpq_seq #(
    .CAPACITY     (CAPACITY),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (s_axis_tuser),
    .in_key     (in_key_wide[KEY_BITS-1:0]),
    .in_payload (in_pay_wide[PAYLOAD_BITS-1:0]),
    .out_free   (out_free),
    .res        (res),
    .root       (root),
    .count      (count),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (re),
    .raddr      (raddr),
    .rdata      (rdata)
  );

  mhpq_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Fit the root entry and count to the result fields
  assign root_key_wide = {{KFW{1'b0}}, root[DW-1:PAYLOAD_BITS]};
  assign root_pay_wide = {{PFW{1'b0}}, root[PAYLOAD_BITS-1:0]};
  assign cnt_wide      = {{NFW{1'b0}}, count};

  assign out_free = !out_valid || m_axis_tready;

  // Result register: load a finished beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      if (count == '0) begin
        out_key     <= '0;
        out_payload <= '0;
      end else begin
        out_key     <= root_key_wide[KFW-1:0];
        out_payload <= root_pay_wide[PFW-1:0];
      end
      out_count  <= cnt_wide[NFW-1:0];
      out_status <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_count, out_payload, out_key};
  assign m_axis_tuser  = out_status;

  `MHPQ_ASSERT_NOW(a_done_needs_room, res.done, out_free, "result overwrites waiting beat")
  `MHPQ_ASSERT_NEXT(a_taken_beat_drops, m_axis_tvalid && m_axis_tready && !res.done,
                    !m_axis_tvalid, "taken beat still shown")

endmodule

`default_nettype wire

// ===== rtl/core/mhpq_store.sv =====
// Heap entry memory: one write port and one registered read port.
`default_nettype none

module mhpq_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, data valid in the next cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mhpq_seq.sv =====
// Heap sequencer: sift up and sift down through one shared key comparator.
`default_nettype none
`include "min_heap_priority_queue_unit_macros.svh"

module mhpq_seq #(
  parameter int CAPACITY     = 64,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 32,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int DW = KEY_BITS + PAYLOAD_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Operation side
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire mhpq_pkg::op_t          in_op,
  input  wire logic [KEY_BITS-1:0]    in_key,
  input  wire logic [PAYLOAD_BITS-1:0] in_payload,
  // Result side
  input  wire logic                   out_free,
  output mhpq_pkg::res_t              res,
  output logic      [DW-1:0]          root,
  output logic      [CW-1:0]          count,
  // Store port
  output logic                        we,
  output logic      [AW-1:0]          waddr,
  output logic      [DW-1:0]          wdata,
  output logic                        re,
  output logic      [AW-1:0]          raddr,
  input  wire logic [DW-1:0]          rdata
);

  localparam int IW = AW + 2;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DN_LOAD = 3'd3;
  localparam logic [2:0] S_DN_RD   = 3'd4;
  localparam logic [2:0] S_DN_CR   = 3'd5;
  localparam logic [2:0] S_DN_CL   = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]              state, state_next;
  logic [CW-1:0]           count_next;
  logic [AW-1:0]           pos, pos_next;
  logic [DW-1:0]           mov, mov_next;
  logic [DW-1:0]           best, best_next;
  logic [AW-1:0]           best_pos, best_pos_next;
  mhpq_pkg::status_t       status, status_next;

  logic                    accept;
  logic [AW-1:0]           pos_m1;
  logic [AW-1:0]           parent;
  logic [IW-1:0]           left_idx;
  logic [IW-1:0]           right_idx;
  logic [IW-1:0]           cnt_ext;
  logic                    l_ok;
  logic                    r_ok;
  logic [KEY_BITS-1:0]     cmp_a;
  logic [KEY_BITS-1:0]     cmp_b;
  logic                    lt;
  logic [DW-1:0]           sel;
  logic [AW-1:0]           sel_pos;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Tree index arithmetic around the current hole
  assign pos_m1    = pos - AW'(1);
  assign parent    = pos_m1 >> 1;
  assign left_idx  = {1'b0, pos, 1'b1};
  assign right_idx = left_idx + IW'(1);
  assign cnt_ext   = {{(IW - CW){1'b0}}, count};
  assign l_ok      = left_idx < cnt_ext;
  assign r_ok      = right_idx < cnt_ext;

  // Shared comparator: moving key against parent, or child against best
  always_comb begin
    if (state == S_UP_CMP) begin
      cmp_a = mov[DW-1:PAYLOAD_BITS];
      cmp_b = rdata[DW-1:PAYLOAD_BITS];
    end else begin
      cmp_a = rdata[DW-1:PAYLOAD_BITS];
      cmp_b = best[DW-1:PAYLOAD_BITS];
    end
  end
  assign lt = cmp_a < cmp_b;

  // Pick the smaller of the best so far and the left child
  always_comb begin
    if (lt) begin
      sel     = rdata;
      sel_pos = left_idx[AW-1:0];
    end else begin
      sel     = best;
      sel_pos = best_pos;
    end
  end

  // Sequence the operation
  always_comb begin
    state_next    = state;
    count_next    = count;
    pos_next      = pos;
    mov_next      = mov;
    best_next     = best;
    best_pos_next = best_pos;
    status_next   = status;
    we            = 1'b0;
    waddr         = pos;
    wdata         = mov;
    re            = 1'b0;
    raddr         = parent;
    res.done      = 1'b0;
    res.status    = status;
    case (state)
      S_IDLE: begin
        if (accept) begin
          status_next = mhpq_pkg::ST_DONE;
          state_next  = S_DONE;
          case (in_op)
            mhpq_pkg::OP_INSERT: begin
              if (count == CW'(CAPACITY)) begin
                status_next = mhpq_pkg::ST_FULL;
              end else begin
                mov_next   = {in_key, in_payload};
                pos_next   = count[AW-1:0];
                count_next = count + CW'(1);
                state_next = S_UP_RD;
              end
            end
            mhpq_pkg::OP_REMOVE: begin
              if (count == '0) begin
                status_next = mhpq_pkg::ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
                if (count != CW'(1)) begin
                  // fetch the last entry to refill the root
                  re         = 1'b1;
                  raddr      = count_next[AW-1:0];
                  state_next = S_DN_LOAD;
                end
              end
            end
            mhpq_pkg::OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          we         = 1'b1;
          state_next = S_DONE;
        end else begin
          re         = 1'b1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (lt) begin
          // pull the parent down into the hole
          wdata      = rdata;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DN_LOAD: begin
        mov_next   = rdata;
        pos_next   = '0;
        state_next = S_DN_RD;
      end
      S_DN_RD: begin
        best_next     = mov;
        best_pos_next = pos;
        if (r_ok) begin
          re         = 1'b1;
          raddr      = right_idx[AW-1:0];
          state_next = S_DN_CR;
        end else if (l_ok) begin
          re         = 1'b1;
          raddr      = left_idx[AW-1:0];
          state_next = S_DN_CL;
        end else begin
          we         = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DN_CR: begin
        if (lt) begin
          best_next     = rdata;
          best_pos_next = right_idx[AW-1:0];
        end
        re         = 1'b1;
        raddr      = left_idx[AW-1:0];
        state_next = S_DN_CL;
      end
      S_DN_CL: begin
        we = 1'b1;
        if (sel_pos == pos) begin
          state_next = S_DONE;
        end else begin
          // lift the smaller child into the hole
          wdata      = sel;
          pos_next   = sel_pos;
          state_next = S_DN_RD;
        end
      end
      S_DONE: begin
        res.done = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers and root copy
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    mov      <= mov_next;
    best     <= best_next;
    best_pos <= best_pos_next;
    status   <= status_next;
    if (we && (waddr == '0)) begin
      root <= wdata;
    end
  end

  `MHPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(CAPACITY), "entry count above capacity")
  `MHPQ_ASSERT_NOW(a_write_in_heap, we, CW'(waddr) < count, "write beyond heap end")
  `MHPQ_ASSERT_NOW(a_read_in_heap, re, CW'(raddr) < count, "read beyond heap end")
  `MHPQ_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready straight after accept")

endmodule

`default_nettype wire
